// ----- design/lvs_pkg.sv -----
// shared types, codes and constants for the lucas v sequence unit
`default_nettype none

package lvs_pkg;

    localparam int WORD_W       = 64;
    localparam int HALF_W       = 32;
    localparam int EXP_IN_W     = 63;
    localparam int DEF_EXP_BITS = 63;
    localparam int NUM_LANES    = 8;

    localparam logic [WORD_W-1:0] WORD_ONE = 64'd1;
    localparam logic [WORD_W-1:0] WORD_TWO = 64'd2;
    localparam logic [WORD_W-1:0] NEG_TWO  = 64'hFFFF_FFFF_FFFF_FFFE;

    // 2x2 matrix, row major
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } mat_t;

    typedef enum logic [1:0] {
        OP_V2,
        OP_SQUARE,
        OP_ACCMUL,
        OP_FINAL
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_V2,
        S_ROUND,
        S_SQUARE,
        S_FINAL,
        S_WAIT1,
        S_WAIT2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic issue;
        op_t  op;
        logic shift_e;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic short_exp;
        logic e_zero;
        logic e_bit0;
        logic e_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/lucas_v_sequence_mod_2_64_unit.sv -----
// top level of the lucas v sequence unit, V(n) = a^n + b^n modulo 2^64
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    root_sum, root_product, exponent
//   out      output     out_valid/out_ready  power_sum
//
// one item at a time; for n below 3 out_valid rises once the item has passed S_V2,
// S_WAIT1, S_WAIT2 and S_DONE; for larger n, with e = n-2, the time is set by the single
// eight-lane matrix multiplier: a squaring per bit of e but the top one, a multiply per
// set bit; each product passes two lane stages and writeback and the next waits for it
// a finished result sits in the output register while the next item is taken
// reset (rst_n low, asynchronous) clears the controller and the output valid
`default_nettype none

module lucas_v_sequence_mod_2_64_unit #(
    parameter int EXP_BITS = lvs_pkg::DEF_EXP_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [lvs_pkg::WORD_W-1:0]   root_sum,
    input  wire logic [lvs_pkg::WORD_W-1:0]   root_product,
    input  wire logic [lvs_pkg::EXP_IN_W-1:0] exponent,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [lvs_pkg::WORD_W-1:0]   power_sum
);
    import lvs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lvs_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .root_sum     (root_sum),
        .root_product (root_product),
        .exponent     (exponent),
        .power_sum    (power_sum)
    );

endmodule

`default_nettype wire

// ----- design/lvs_mul64.sv -----
// one multiplier lane: 64x64 product modulo 2^64 from three 32x32 products, two stages
`default_nettype none

module lvs_mul64 (
    input  wire logic                      clk,
    input  wire logic [lvs_pkg::WORD_W-1:0] x,
    input  wire logic [lvs_pkg::WORD_W-1:0] y,
    output logic      [lvs_pkg::WORD_W-1:0] prod
);
    import lvs_pkg::*;

    logic [WORD_W-1:0] ll_reg;
    logic [HALF_W-1:0] lh_reg;
    logic [HALF_W-1:0] hl_reg;
    logic [WORD_W-1:0] prod_reg;

    // high x high lands above bit 63 and drops out
    always_ff @(posedge clk)
    begin
        ll_reg   <= WORD_W'(x[HALF_W-1:0]) * WORD_W'(y[HALF_W-1:0]);
        lh_reg   <= x[HALF_W-1:0] * y[WORD_W-1:HALF_W];
        hl_reg   <= x[WORD_W-1:HALF_W] * y[HALF_W-1:0];
        prod_reg <= ll_reg + {lh_reg + hl_reg, {HALF_W{1'b0}}};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- design/lvs_datapath.sv -----
// datapath: operand registers, eight multiplier lanes, pair sums and writeback
`default_nettype none

module lvs_datapath #(
    parameter int EXP_BITS = lvs_pkg::DEF_EXP_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lvs_pkg::cmd_t               cmd,
    output lvs_pkg::stat_t                   stat,
    input  wire logic [lvs_pkg::WORD_W-1:0]   root_sum,
    input  wire logic [lvs_pkg::WORD_W-1:0]   root_product,
    input  wire logic [lvs_pkg::EXP_IN_W-1:0] exponent,
    output logic      [lvs_pkg::WORD_W-1:0]   power_sum
);
    import lvs_pkg::*;

    localparam int EW = (EXP_BITS < EXP_IN_W) ? EXP_BITS : EXP_IN_W;

    logic [WORD_W-1:0] p_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] v2_reg;
    logic [WORD_W-1:0] fin_reg;
    logic [WORD_W-1:0] out_reg;
    mat_t              base_reg;
    mat_t              acc_reg;
    logic [EW-1:0]     e_reg;
    logic              n0_reg;
    logic              n1_reg;
    logic              n2_reg;

    logic              vld_s1_reg;
    logic              vld_s2_reg;
    op_t               op_s1_reg;
    op_t               op_s2_reg;

    logic [WORD_W-1:0] n64;
    logic [WORD_W-1:0] lx [NUM_LANES];
    logic [WORD_W-1:0] ly [NUM_LANES];
    logic [WORD_W-1:0] lp [NUM_LANES];
    logic [WORD_W-1:0] r0, r1, r2, r3;
    mat_t              mx;
    mat_t              my;

    assign n64 = WORD_W'(exponent[EW-1:0]);

    // lane operands for each operation
    always_comb
    begin
        mx = (cmd.op == OP_ACCMUL) ? acc_reg : base_reg;
        my = base_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lx[i] = '0;
            ly[i] = '0;
        end
        case (cmd.op)
            OP_V2:
            begin
                lx[0] = p_reg;  ly[0] = p_reg;
                lx[1] = q_reg;  ly[1] = NEG_TWO;
            end
            OP_FINAL:
            begin
                lx[0] = v2_reg; ly[0] = acc_reg.a;
                lx[1] = p_reg;  ly[1] = acc_reg.b;
            end
            OP_SQUARE, OP_ACCMUL:
            begin
                lx[0] = mx.a; ly[0] = my.a;
                lx[1] = mx.b; ly[1] = my.c;
                lx[2] = mx.a; ly[2] = my.b;
                lx[3] = mx.b; ly[3] = my.d;
                lx[4] = mx.c; ly[4] = my.a;
                lx[5] = mx.d; ly[5] = my.c;
                lx[6] = mx.c; ly[6] = my.b;
                lx[7] = mx.d; ly[7] = my.d;
            end
            default:
            begin
                lx[0] = '0;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lvs_mul64 u_mul (
            .clk  (clk),
            .x    (lx[g]),
            .y    (ly[g]),
            .prod (lp[g])
        );
    end

    assign r0 = lp[0] + lp[1];
    assign r1 = lp[2] + lp[3];
    assign r2 = lp[4] + lp[5];
    assign r3 = lp[6] + lp[7];

    // operation tag follows the two lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
            op_s1_reg  <= OP_V2;
            op_s2_reg  <= OP_V2;
        end
        else
        begin
            vld_s1_reg <= cmd.issue;
            vld_s2_reg <= vld_s1_reg;
            op_s1_reg  <= cmd.op;
            op_s2_reg  <= op_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            p_reg    <= root_sum;
            q_reg    <= root_product;
            base_reg <= '{a: root_sum, b: WORD_W'(0) - root_product, c: WORD_ONE, d: '0};
            acc_reg  <= '{a: WORD_ONE, b: '0, c: '0, d: WORD_ONE};
            e_reg    <= EW'(n64 - WORD_TWO);
            n0_reg   <= (n64 == WORD_W'(0));
            n1_reg   <= (n64 == WORD_W'(1));
            n2_reg   <= (n64 == WORD_W'(2));
        end
        else
        begin
            if (cmd.shift_e)
            begin
                e_reg <= e_reg >> 1;
            end
            if (vld_s2_reg)
            begin
                case (op_s2_reg)
                    OP_V2:     v2_reg   <= r0;
                    OP_SQUARE: base_reg <= '{a: r0, b: r1, c: r2, d: r3};
                    OP_ACCMUL: acc_reg  <= '{a: r0, b: r1, c: r2, d: r3};
                    OP_FINAL:  fin_reg  <= r0;
                    default:   fin_reg  <= r0;
                endcase
            end
        end
        if (cmd.load_out)
        begin
            if (n0_reg)
            begin
                out_reg <= WORD_TWO;
            end
            else if (n1_reg)
            begin
                out_reg <= p_reg;
            end
            else if (n2_reg)
            begin
                out_reg <= v2_reg;
            end
            else
            begin
                out_reg <= fin_reg;
            end
        end
    end

    assign stat.short_exp = n0_reg | n1_reg | n2_reg;
    assign stat.e_zero    = (e_reg == '0);
    assign stat.e_bit0    = e_reg[0];
    assign stat.e_last    = ((e_reg >> 1) == '0);
    assign power_sum      = out_reg;

endmodule

`default_nettype wire

// ----- design/lvs_ctrl.sv -----
// controller: sequences square-and-multiply steps and the output handshake
`default_nettype none

module lvs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire lvs_pkg::stat_t stat,
    output lvs_pkg::cmd_t       cmd
);
    import lvs_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_V2;
                end
            end
            S_V2:
            begin
                state_next = S_WAIT1;
                ret_next   = stat.short_exp ? S_DONE : S_ROUND;
            end
            S_ROUND:
            begin
                if (stat.e_zero)
                begin
                    state_next = S_FINAL;
                end
                else if (stat.e_bit0)
                begin
                    state_next = S_WAIT1;
                    ret_next   = S_SQUARE;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (stat.e_last)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_WAIT1;
                    ret_next   = S_ROUND;
                end
            end
            S_FINAL:
            begin
                state_next = S_WAIT1;
                ret_next   = S_DONE;
            end
            S_WAIT1:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                state_next = ret_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '{load_item: 1'b0, issue: 1'b0, op: OP_V2, shift_e: 1'b0, load_out: 1'b0};
        in_ready  = 1'b0;
        out_valid = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_V2:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_V2;
            end
            S_ROUND:
            begin
                cmd.op    = OP_ACCMUL;
                cmd.issue = !stat.e_zero && stat.e_bit0;
            end
            S_SQUARE:
            begin
                cmd.op      = OP_SQUARE;
                cmd.issue   = !stat.e_last;
                cmd.shift_e = 1'b1;
            end
            S_FINAL:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_FINAL;
            end
            S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
